FILE: src/worst_fit_chunk_allocator_unit_defines.svh
`ifndef WORST_FIT_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH
`define WORST_FIT_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define WFCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define WFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/wfca_pkg.sv
package wfca_pkg;

  localparam int unsigned MaxChunksDef = 64;
  localparam int unsigned ValueW       = 16;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned ChunkIdxW    = 6;
  localparam int unsigned AllocCntW    = 7;
  localparam int unsigned PDataW       = 32;
  localparam int unsigned PAddrW       = 3;

  localparam logic [ValueW-1:0] CapResetVal = ValueW'(1024);
  localparam logic [PAddrW-1:0] RegCapAddr  = PAddrW'(0);

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_LOADED  = 3'd0,
    ST_GRANTED = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_HALTED  = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

endpackage

FILE: src/wfca_cell.sv
// One table entry plus one stage of the best-candidate chain.
module wfca_cell import wfca_pkg::*; #(
  parameter int unsigned MaxChunks = MaxChunksDef,
  parameter int unsigned Idx       = 0,
  localparam int unsigned IdxW     = $clog2(MaxChunks),
  localparam int unsigned CntW     = $clog2(MaxChunks + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic              clr_en_i,
  input  logic [IdxW-1:0]   sel_idx_i,
  input  logic [ValueW-1:0] wr_size_i,
  input  logic [CntW-1:0]   count_i,
  input  logic [ValueW-1:0] req_val_i,
  input  logic [ValueW-1:0] cap_i,
  input  logic              found_i,
  input  logic [ValueW-1:0] size_i,
  input  logic [IdxW-1:0]   idx_i,
  output logic              found_o,
  output logic [ValueW-1:0] size_o,
  output logic [IdxW-1:0]   idx_o
);

  logic [ValueW-1:0] entry_size_q;
  logic              entry_free_q;
  logic              found_q;
  logic [ValueW-1:0] size_q;
  logic [IdxW-1:0]   idx_q;
  logic              selected;
  logic              hit;
  logic              take;

  assign selected = (sel_idx_i == IdxW'(Idx));

  // Candidate only if the entry is loaded, free and in the allowed size window.
  assign hit = (CntW'(Idx) < count_i) && entry_free_q &&
               (entry_size_q >= req_val_i) && (entry_size_q <= cap_i);
  // Strictly larger wins, so ties keep the earlier entry.
  assign take = hit && (!found_i || (entry_size_q > size_i));

  always_ff @(posedge clk_i) begin
    if (wr_en_i && selected) begin
      entry_size_q <= wr_size_i;
      entry_free_q <= 1'b1;
    end else if (clr_en_i && selected) begin
      entry_free_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_i || take;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= take ? entry_size_q : size_i;
    idx_q  <= take ? IdxW'(Idx) : idx_i;
  end

  assign found_o = found_q;
  assign size_o  = size_q;
  assign idx_o   = idx_q;

endmodule

FILE: src/worst_fit_chunk_allocator_unit.sv
// Worst-fit chunk allocator.
// Input channel (in_valid_i / in_stall_o): operation_i selects load (append a
// free chunk of size value_i) or request (grant the largest free chunk with
// value_i <= size <= budget cap, earliest entry on ties).
// Output channel (out_valid_o / out_stall_i): one result per item, held in an
// output register; while the receiver stalls the result holds and a request
// that needs a scan may still be taken.
// A load, or a request after halt, shows its result in the cycle after the
// transfer. Any other request goes through a scan: the table sits in
// a chain of MaxChunks cells and the best-candidate token moves one cell per
// cycle, then the decide state picks grant, refusal or halt once the output
// slot is free. One item is in work at a time.
// The budget cap is written over the APB port at byte address 0 (reset 1024).
// Reset clears the chunk count, the running total, the grant count and the
// halt flag; table entries beyond the chunk count are never looked at.
`include "worst_fit_chunk_allocator_unit_defines.svh"

module worst_fit_chunk_allocator_unit import wfca_pkg::*; #(
  parameter int unsigned MaxChunks = MaxChunksDef,
  localparam int unsigned IdxW     = $clog2(MaxChunks),
  localparam int unsigned CntW     = $clog2(MaxChunks + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input item
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [ValueW-1:0]    value_i,
  // result item
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [StatusW-1:0]   status_o,
  output logic [ChunkIdxW-1:0] chunk_index_o,
  output logic [ValueW-1:0]    chunk_size_o,
  output logic [ValueW-1:0]    total_allocated_o,
  output logic [AllocCntW-1:0] allocation_count_o,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PAddrW-1:0]    paddr,
  input  logic [PDataW-1:0]    pwdata,
  output logic [PDataW-1:0]    prdata,
  output logic                 pready
);

  state_e               state_q, state_d;
  logic [IdxW-1:0]      scan_cnt_q, scan_cnt_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [ValueW-1:0]    total_q, total_d;
  logic [AllocCntW-1:0] grant_q, grant_d;
  logic                 halted_q, halted_d;
  logic [ValueW-1:0]    cap_q;
  logic [ValueW-1:0]    req_val_q, req_val_d;

  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [ChunkIdxW-1:0] chunk_index_q, chunk_index_d;
  logic [ValueW-1:0]    chunk_size_q, chunk_size_d;

  logic                 in_fire;
  logic                 slot_busy;
  logic                 needs_slot;
  logic                 cfg_write;
  logic                 wr_en;
  logic                 clr_en;
  logic [IdxW-1:0]      sel_idx;
  logic [ValueW:0]      grant_sum;

  logic                 found_c [MaxChunks];
  logic [ValueW-1:0]    size_c  [MaxChunks];
  logic [IdxW-1:0]      idx_c   [MaxChunks];

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == RegCapAddr);
  assign prdata    = (paddr == RegCapAddr) ? PDataW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapResetVal;
    end else if (cfg_write) begin
      cap_q <= pwdata[ValueW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: the head sees no candidate, the tail holds the winner
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < MaxChunks; g++) begin : g_cell
    logic              found_in;
    logic [ValueW-1:0] size_in;
    logic [IdxW-1:0]   idx_in;

    if (g == 0) begin : g_head
      assign found_in = 1'b0;
      assign size_in  = '0;
      assign idx_in   = '0;
    end else begin : g_link
      assign found_in = found_c[g-1];
      assign size_in  = size_c[g-1];
      assign idx_in   = idx_c[g-1];
    end

    wfca_cell #(
      .MaxChunks (MaxChunks),
      .Idx       (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en),
      .clr_en_i  (clr_en),
      .sel_idx_i (sel_idx),
      .wr_size_i (value_i),
      .count_i   (count_q),
      .req_val_i (req_val_q),
      .cap_i     (cap_q),
      .found_i   (found_in),
      .size_i    (size_in),
      .idx_i     (idx_in),
      .found_o   (found_c[g]),
      .size_o    (size_c[g]),
      .idx_o     (idx_c[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  // The output slot is free if empty or drained in this cycle.
  assign slot_busy  = out_valid_q && out_stall_i;
  // Loads and requests after halt write the result at once; scans do not.
  assign needs_slot = (operation_i == OP_LOAD) || halted_q;
  assign in_stall_o = (state_q != S_IDLE) || (slot_busy && needs_slot);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign grant_sum  = {1'b0, total_q} + {1'b0, size_c[MaxChunks-1]};

  always_comb begin
    state_d       = state_q;
    scan_cnt_d    = scan_cnt_q;
    count_d       = count_q;
    total_d       = total_q;
    grant_d       = grant_q;
    halted_d      = halted_q;
    req_val_d     = req_val_q;
    out_valid_d   = slot_busy;
    status_d      = status_q;
    chunk_index_d = chunk_index_q;
    chunk_size_d  = chunk_size_q;
    wr_en         = 1'b0;
    clr_en        = 1'b0;
    sel_idx       = count_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (operation_i == OP_LOAD) begin
            out_valid_d   = 1'b1;
            chunk_size_d  = '0;
            if (count_q >= CntW'(MaxChunks)) begin
              status_d      = ST_FULL;
              chunk_index_d = '0;
            end else begin
              wr_en         = 1'b1;
              count_d       = count_q + CntW'(1);
              status_d      = ST_LOADED;
              chunk_index_d = ChunkIdxW'(count_q);
            end
          end else if (halted_q) begin
            out_valid_d   = 1'b1;
            status_d      = ST_HALTED;
            chunk_index_d = '0;
            chunk_size_d  = '0;
          end else begin
            req_val_d  = value_i;
            scan_cnt_d = '0;
            state_d    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Advance until the token has crossed every cell.
        scan_cnt_d = scan_cnt_q + IdxW'(1);
        if (scan_cnt_q == IdxW'(MaxChunks - 1)) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (!slot_busy) begin
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
          chunk_index_d = '0;
          chunk_size_d  = '0;
          if (total_q == cap_q) begin
            halted_d = 1'b1;
            status_d = ST_HALTED;
          end else if (found_c[MaxChunks-1] && (grant_sum > {1'b0, cap_q})) begin
            halted_d = 1'b1;
            status_d = ST_HALTED;
          end else if (!found_c[MaxChunks-1]) begin
            status_d = ST_NOFIT;
          end else begin
            clr_en        = 1'b1;
            sel_idx       = idx_c[MaxChunks-1];
            total_d       = grant_sum[ValueW-1:0];
            grant_d       = grant_q + AllocCntW'(1);
            status_d      = ST_GRANTED;
            chunk_index_d = ChunkIdxW'(idx_c[MaxChunks-1]);
            chunk_size_d  = size_c[MaxChunks-1];
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      count_q     <= '0;
      total_q     <= '0;
      grant_q     <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      count_q     <= count_d;
      total_q     <= total_d;
      grant_q     <= grant_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_val_q     <= req_val_d;
    status_q      <= status_d;
    chunk_index_q <= chunk_index_d;
    chunk_size_q  <= chunk_size_d;
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign chunk_index_o      = chunk_index_q;
  assign chunk_size_o       = chunk_size_q;
  assign total_allocated_o  = total_q;
  assign allocation_count_o = grant_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `WFCA_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "halt flag dropped")
  `WFCA_ASSERT_NOW(a_accept_idle, in_fire, state_q == S_IDLE, "item taken while busy")
  `WFCA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(MaxChunks), "chunk count overflow")
  `WFCA_ASSERT_NOW(a_grant_in_cap, out_valid_o && (status_o == ST_GRANTED),
                   total_q <= cap_q, "grant pushed total past cap")

endmodule

FILE: tb/sv/worst_fit_chunk_allocator_unit_test.sv
module worst_fit_chunk_allocator_unit_test import wfca_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxChunks       = MaxChunksDef;
  // Random loads stop short of a full table so that loads after the halt
  // still find a slot before the table-full status shows up.
  localparam int unsigned RandomLoadLimit = MaxChunks - 4;
  // Keep random chunks small: the sum of a whole table stays below the
  // largest cap, so the random phases never halt by accident.
  localparam int unsigned MaxRandomChunk  = 1000;
  localparam int unsigned RandomPhases    = 4;
  localparam int unsigned PhaseItems      = 225;
  localparam int unsigned DrainCycles     = MaxChunks + 10;
  localparam int unsigned WatchdogLimit   = 4000;

  typedef struct packed {
    status_e               status;
    logic [ChunkIdxW-1:0]  index;
    logic [ValueW-1:0]     size;
    logic [ValueW-1:0]     total;
    logic [AllocCntW-1:0]  grants;
  } alloc_reply_t;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_RUNS
  } stall_mode_e;

  // Shadow copy of the chunk table; predicts one reply per accepted transfer
  class alloc_tracker;
    logic [ValueW-1:0]    cap;
    logic [ValueW-1:0]    sizes [MaxChunks];
    bit                   is_free [MaxChunks];
    int unsigned          loaded;
    logic [ValueW-1:0]    total;
    logic [AllocCntW-1:0] grants;
    bit                   halted;
    alloc_reply_t         pending_allocs [$];
    int unsigned          mismatches;

    function new();
      cap        = CapResetVal;
      loaded     = 0;
      total      = '0;
      grants     = '0;
      halted     = 1'b0;
      mismatches = 0;
    endfunction

    function void apply_item(op_e op, logic [ValueW-1:0] val);
      alloc_reply_t r;
      int           best;
      bit           found;
      r.status = ST_LOADED;
      r.index  = '0;
      r.size   = '0;
      best     = 0;
      found    = 1'b0;
      if (op == OP_LOAD) begin
        if (loaded >= MaxChunks) begin
          r.status = ST_FULL;
        end else begin
          sizes[loaded]   = val;
          is_free[loaded] = 1'b1;
          r.index         = ChunkIdxW'(loaded);
          loaded++;
        end
      end else if (halted) begin
        r.status = ST_HALTED;
      end else begin
        // largest free chunk in [val, cap], earliest entry wins a tie
        for (int i = 0; i < int'(loaded); i++) begin
          if (is_free[i] && sizes[i] >= val && sizes[i] <= cap &&
              (!found || sizes[i] > sizes[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        // the used-up check comes first, even when nothing fits
        if (total == cap || (found && int'(total) + int'(sizes[best]) > int'(cap))) begin
          halted   = 1'b1;
          r.status = ST_HALTED;
        end else if (!found) begin
          r.status = ST_NOFIT;
        end else begin
          is_free[best] = 1'b0;
          total         = total + sizes[best];
          grants        = grants + 1'b1;
          r.status      = ST_GRANTED;
          r.index       = ChunkIdxW'(best);
          r.size        = sizes[best];
        end
      end
      r.total  = total;
      r.grants = grants;
      pending_allocs.push_back(r);
    endfunction

    function void check_result(logic [StatusW-1:0] status, logic [ChunkIdxW-1:0] index,
                               logic [ValueW-1:0] size, logic [ValueW-1:0] tot,
                               logic [AllocCntW-1:0] cnt);
      alloc_reply_t e;
      if (pending_allocs.size() == 0) begin
        $error("result transfer with no item pending: status %0d", status);
        mismatches++;
        return;
      end
      e = pending_allocs.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        mismatches++;
      end
      if (index !== e.index) begin
        $error("chunk_index: expected %0d, got %0d", e.index, index);
        mismatches++;
      end
      if (size !== e.size) begin
        $error("chunk_size: expected %0d, got %0d", e.size, size);
        mismatches++;
      end
      if (tot !== e.total) begin
        $error("total_allocated: expected %0d, got %0d", e.total, tot);
        mismatches++;
      end
      if (cnt !== e.grants) begin
        $error("allocation_count: expected %0d, got %0d", e.grants, cnt);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 operation_i = 1'b0;
  logic [ValueW-1:0]    value_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [StatusW-1:0]   status_o;
  logic [ChunkIdxW-1:0] chunk_index_o;
  logic [ValueW-1:0]    chunk_size_o;
  logic [ValueW-1:0]    total_allocated_o;
  logic [AllocCntW-1:0] allocation_count_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [PAddrW-1:0]    paddr       = '0;
  logic [PDataW-1:0]    pwdata      = '0;
  logic [PDataW-1:0]    prdata;
  logic                 pready;

  alloc_tracker tracker = new();

  worst_fit_chunk_allocator_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 0;
  end

  // Monitor both channels; a transfer happens where valid is high and stall low
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        tracker.check_result(status_o, chunk_index_o, chunk_size_o, total_allocated_o,
                             allocation_count_o);
      end
      if (in_valid_i && !in_stall_o) begin
        tracker.apply_item(op_e'(operation_i), value_i);
      end
    end
  end

  // Receiver back-pressure: switch between a few stall patterns every so often,
  // including long stretches with no stall at all.
  stall_mode_e stall_mode  = STALL_NONE;
  int unsigned mode_left   = 0;
  int unsigned run_left    = 0;
  int unsigned stall_tick  = 0;
  logic        stall_level = 1'b0;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(40, 300);
    end
    mode_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE: begin
        stall_level = 1'b0;
      end
      STALL_RANDOM: begin
        stall_level = $urandom_range(0, 1);
      end
      STALL_PERIODIC: begin
        stall_level = (stall_tick % 5) < 2;
      end
      default: begin
        if (run_left == 0) begin
          stall_level = ~stall_level;
          run_left    = $urandom_range(1, 30);
        end
        run_left--;
      end
    endcase
    out_stall_i <= stall_level;
  end

  // Watchdog: end the run if nothing moves on either channel or the APB port
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL worst_fit_chunk_allocator_unit");
      $finish;
    end
  end

  // Sender: items go out in bursts; a fresh burst may open with an idle gap.
  int unsigned burst_left = 0;

  task automatic send_item(op_e op, logic [ValueW-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    // hold the payload until the transfer
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every reply has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_allocs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  // APB write of the budget cap: setup cycle, then access cycle until pready
  task automatic write_cap(logic [ValueW-1:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegCapAddr;
    pwdata  <= PDataW'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.cap = cap;
  endtask

  task automatic send_random_item();
    logic [ValueW-1:0] val;
    if (tracker.loaded < RandomLoadLimit && $urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 9))
        0:       val = '0;
        1:       val = ValueW'(MaxRandomChunk);
        default: val = ValueW'($urandom_range(0, MaxRandomChunk));
      endcase
      send_item(OP_LOAD, val);
    end else begin
      case ($urandom_range(0, 9))
        0:       val = '0;
        1:       val = '1;
        2, 3:    val = ValueW'($urandom);
        default: val = ValueW'($urandom_range(0, MaxRandomChunk));
      endcase
      send_item(OP_REQUEST, val);
    end
  endtask

  initial begin
    int free_sum;
    int headroom;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset cap: empty table, ties, a chunk above the cap, zero-size chunk
    send_item(OP_REQUEST, 7);
    send_item(OP_LOAD, 0);
    send_item(OP_LOAD, 300);
    send_item(OP_LOAD, 300);
    send_item(OP_LOAD, 1);
    send_item(OP_LOAD, 1025);
    send_item(OP_REQUEST, '1);
    send_item(OP_REQUEST, 1025);
    send_item(OP_REQUEST, 2);
    send_item(OP_REQUEST, 2);
    send_item(OP_REQUEST, 0);
    send_item(OP_REQUEST, 0);
    send_item(OP_REQUEST, 0);

    // Cap lowered below the running total with nothing that fits
    drain_results();
    write_cap('0);
    send_item(OP_REQUEST, 0);

    // Largest cap releases the chunk that sat above the old one
    drain_results();
    write_cap('1);
    send_item(OP_REQUEST, 1025);
    send_item(OP_REQUEST, 0);

    // Random phases; odd phases use a random cap with room for every chunk
    for (int phase = 0; phase < RandomPhases; phase++) begin
      drain_results();
      if (phase % 2 == 0) begin
        write_cap('1);
      end else begin
        free_sum = 0;
        for (int i = 0; i < int'(tracker.loaded); i++) begin
          if (tracker.is_free[i]) free_sum += tracker.sizes[i];
        end
        headroom = int'(tracker.total) + free_sum + 1 +
                   (int'(RandomLoadLimit) + 1 - int'(tracker.loaded)) * MaxRandomChunk;
        if (headroom > 65535) headroom = 65535;
        write_cap(ValueW'($urandom_range(headroom, 65535)));
      end
      repeat (PhaseItems) send_random_item();
    end

    // Halt, either with the budget used up or with a chunk that overshoots it
    drain_results();
    if ($urandom_range(0, 1) == 0) begin
      write_cap(tracker.total);
      send_item(OP_REQUEST, ValueW'($urandom));
    end else begin
      write_cap(tracker.total + 1'b1);
      send_item(OP_LOAD, 2);
      send_item(OP_REQUEST, 0);
    end
    send_item(OP_REQUEST, 5);

    // Loads still land after the halt, until the table is full
    send_item(OP_LOAD, '1);
    repeat (MaxChunks - tracker.loaded + 2) send_item(OP_LOAD, ValueW'($urandom));
    repeat (25) send_item(op_e'($urandom_range(0, 1)), ValueW'($urandom));

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_allocs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.pending_allocs.size() == 0) begin
      $display("PASS worst_fit_chunk_allocator_unit");
    end else begin
      $display("FAIL worst_fit_chunk_allocator_unit");
    end
    $finish;
  end

endmodule
